// ===== hdl/single_server_queue_monitor_assert.svh =====
// Assertion macros shared by the queue monitor modules.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef SINGLE_SERVER_QUEUE_MONITOR_ASSERT_SVH
`define SINGLE_SERVER_QUEUE_MONITOR_ASSERT_SVH

// Same-cycle implication, off while reset is held.
`define SSQM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ssqm: same-cycle check failed");

// Next-cycle implication, off while reset is held.
`define SSQM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ssqm: next-cycle check failed");

`endif

// ===== hdl/ssqm_pkg.sv =====
// Shared types and constants of the single server queue monitor.
// No dependencies; imported by the controller, datapath and top level.
package ssqm_pkg;

    localparam int QUEUE_DEPTH = 128;
    localparam int TIME_BITS   = 32;

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W   = 32;
    localparam int SUM_W  = 64;
    localparam int PROD_W = TIME_BITS + CNT_W;

    localparam logic FUNC_ARRIVAL   = 1'b0;
    localparam logic FUNC_DEPARTURE = 1'b1;

    localparam logic [1:0] REC_ARRIVAL = 2'd0;
    localparam logic [1:0] REC_START   = 2'd1;
    localparam logic [1:0] REC_DEPART  = 2'd2;

    typedef struct packed {
        logic        func;
        logic [31:0] event_time;
    } t_in;

    typedef struct packed {
        logic [1:0]       record_kind;
        logic [31:0]      record_time;
        logic [ID_W-1:0]  item_id;
        logic             server_busy;
        logic [7:0]       queue_length;
        logic             last_of_run;
        logic [31:0]      served_count;
        logic [SUM_W-1:0] queue_delay_sum;
        logic [SUM_W-1:0] system_delay_sum;
        logic [SUM_W-1:0] queue_area;
        logic [SUM_W-1:0] busy_area;
        logic [SUM_W-1:0] system_area;
    } t_out;

    // Controller to datapath: one strobe per step of an event.
    typedef struct packed {
        logic load;
        logic delta;
        logic mul;
        logic acc;
        logic rec0;
        logic rec1;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic skip;
        logic two_rec;
    } t_stat;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

// ===== hdl/ssqm_ctrl.sv =====
// Event sequencer of the queue monitor: steps each event through the datapath.
// Depends on ssqm_pkg and single_server_queue_monitor_assert.svh.
`include "single_server_queue_monitor_assert.svh"

module ssqm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  ssqm_pkg::t_stat i_stat,
    output ssqm_pkg::t_cmd  o_cmd
);
    import ssqm_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DELTA = 6'b000010,
        S_MUL   = 6'b000100,
        S_ACC   = 6'b001000,
        S_REC0  = 6'b010000,
        S_REC1  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DELTA;
                end
            end
            S_DELTA: begin
                // drop a departure that finds the server idle
                if (i_stat.skip) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.delta = 1'b1;
                    n_state     = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = S_REC0;
            end
            S_REC0: begin
                if (out_free) begin
                    o_cmd.rec0  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = i_stat.two_rec ? S_REC1 : S_IDLE;
                end
            end
            S_REC1: begin
                if (out_free) begin
                    o_cmd.rec1  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `SSQM_ASSERT_NEXT(a_accept_to_delta, i_in_valid && o_in_ready, r_state == S_DELTA)
    `SSQM_ASSERT_NEXT(a_second_record_follows, o_cmd.rec0 && i_stat.two_rec, r_state == S_REC1)

endmodule

// ===== hdl/ssqm_dp.sv =====
// Datapath of the queue monitor: server state, wait FIFO, sums and the record register.
// Depends on ssqm_pkg and single_server_queue_monitor_assert.svh.
`include "single_server_queue_monitor_assert.svh"

module ssqm_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ssqm_pkg::t_cmd  i_cmd,
    input  ssqm_pkg::t_in   i_in,
    output ssqm_pkg::t_stat o_stat,
    output ssqm_pkg::t_out  o_out
);
    import ssqm_pkg::*;

    typedef struct packed {
        logic [ID_W-1:0]      id;
        logic [TIME_BITS-1:0] arr;
    } t_entry;

    t_entry mem_wait [QUEUE_DEPTH];
    t_entry r_rd;
    logic   mem_we;
    t_entry mem_wdata;

    // event payload and intermediate results
    logic                 r_func;
    logic [TIME_BITS-1:0] r_now;
    logic [31:0]          r_raw;
    logic [TIME_BITS-1:0] r_dt;
    logic [TIME_BITS-1:0] r_sdt;
    logic [TIME_BITS-1:0] r_wdt;
    logic [PROD_W-1:0]    r_prod;
    t_out                 r_out, n_out;

    // server and statistics state
    logic                 r_busy, n_busy;
    logic [PTR_W-1:0]     r_head, n_head;
    logic [PTR_W-1:0]     r_tail, n_tail;
    logic [CNT_W-1:0]     r_wc, n_wc;
    logic [ID_W-1:0]      r_ctr, n_ctr;
    logic [ID_W-1:0]      r_sid, n_sid;
    logic [TIME_BITS-1:0] r_sarr, n_sarr;
    logic [31:0]          r_departed, n_departed;
    logic [SUM_W-1:0]     r_wait_sum, n_wait_sum;
    logic [SUM_W-1:0]     r_stay_sum, n_stay_sum;
    logic [SUM_W-1:0]     r_area_wait, n_area_wait;
    logic [SUM_W-1:0]     r_area_busy, n_area_busy;
    logic [SUM_W-1:0]     r_area_all, n_area_all;
    logic [TIME_BITS-1:0] r_prev, n_prev;

    logic [SUM_W-1:0]     busy_dt;
    logic [1:0]           rec_kind;
    logic [ID_W-1:0]      rec_id;
    logic                 rec_busy;
    logic                 rec_last;
    logic [CNT_W-1:0]     rec_qlen;

    assign o_out = r_out;
    assign o_stat.skip    = (r_func == FUNC_DEPARTURE) && !r_busy;
    assign o_stat.two_rec = (r_func == FUNC_ARRIVAL) ? !r_busy : (r_wc != '0);
    assign busy_dt        = r_busy ? SUM_W'(r_dt) : '0;

    always_comb begin
        n_busy      = r_busy;
        n_head      = r_head;
        n_tail      = r_tail;
        n_wc        = r_wc;
        n_ctr       = r_ctr;
        n_sid       = r_sid;
        n_sarr      = r_sarr;
        n_departed  = r_departed;
        n_wait_sum  = r_wait_sum;
        n_stay_sum  = r_stay_sum;
        n_area_wait = r_area_wait;
        n_area_busy = r_area_busy;
        n_area_all  = r_area_all;
        n_prev      = r_prev;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_wdata   = '0;
        rec_kind    = REC_ARRIVAL;
        rec_id      = '0;
        rec_busy    = 1'b0;
        rec_last    = 1'b0;
        rec_qlen    = r_wc;

        if (i_cmd.delta) begin
            n_prev = r_now;
        end

        if (i_cmd.acc) begin
            n_area_wait = r_area_wait + SUM_W'(r_prod);
            n_area_busy = r_area_busy + busy_dt;
            n_area_all  = r_area_all + SUM_W'(r_prod) + busy_dt;
        end

        if (i_cmd.rec0) begin
            if (r_func == FUNC_ARRIVAL) begin
                n_ctr    = r_ctr + 1'b1;
                rec_kind = REC_ARRIVAL;
                rec_id   = n_ctr;
                if (!r_busy) begin
                    n_busy   = 1'b1;
                    n_sid    = n_ctr;
                    n_sarr   = r_now;
                    rec_busy = 1'b0;
                    rec_last = 1'b0;
                end else begin
                    rec_busy = 1'b1;
                    rec_last = 1'b1;
                    // drop the arrival when the FIFO is full
                    if (r_wc != CNT_W'(QUEUE_DEPTH)) begin
                        mem_we        = 1'b1;
                        mem_wdata.id  = n_ctr;
                        mem_wdata.arr = r_now;
                        n_tail        = ptr_next(r_tail);
                        n_wc          = r_wc + 1'b1;
                    end
                end
            end else begin
                n_departed = r_departed + 1'b1;
                n_stay_sum = r_stay_sum + SUM_W'(r_sdt);
                rec_kind   = REC_DEPART;
                rec_id     = r_sid;
                if (r_wc != '0) begin
                    rec_busy = 1'b1;
                    rec_last = 1'b0;
                end else begin
                    rec_busy = 1'b0;
                    rec_last = 1'b1;
                    n_busy   = 1'b0;
                    n_sid    = '0;
                    n_sarr   = '0;
                end
            end
        end

        if (i_cmd.rec1) begin
            if (r_func == FUNC_DEPARTURE) begin
                // start the FIFO head
                n_head     = ptr_next(r_head);
                n_wc       = r_wc - 1'b1;
                n_sid      = r_rd.id;
                n_sarr     = r_rd.arr;
                n_wait_sum = r_wait_sum + SUM_W'(r_wdt);
            end
            rec_kind = REC_START;
            rec_id   = n_sid;
            rec_busy = 1'b1;
            rec_last = 1'b1;
            rec_qlen = n_wc;
        end

        if (i_cmd.rec0 || i_cmd.rec1) begin
            n_out.record_kind      = rec_kind;
            n_out.record_time      = r_raw;
            n_out.item_id          = rec_id;
            n_out.server_busy      = rec_busy;
            n_out.queue_length     = 8'(rec_qlen);
            n_out.last_of_run      = rec_last;
            n_out.served_count     = n_departed;
            n_out.queue_delay_sum  = n_wait_sum;
            n_out.system_delay_sum = n_stay_sum;
            n_out.queue_area       = n_area_wait;
            n_out.busy_area        = n_area_busy;
            n_out.system_area      = n_area_all;
        end
    end

    // FIFO storage, registered read of the head at event load
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_wait[r_tail] <= mem_wdata;
        end
        if (i_cmd.load) begin
            r_rd <= mem_wait[r_head];
        end
    end

    // payload and intermediate registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_in.func;
            r_now  <= TIME_BITS'(i_in.event_time);
            r_raw  <= i_in.event_time;
        end
        if (i_cmd.delta) begin
            r_dt  <= r_now - r_prev;
            r_sdt <= r_now - r_sarr;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_dt) * PROD_W'(r_wc);
            r_wdt  <= r_now - r_rd.arr;
        end
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_head      <= '0;
            r_tail      <= '0;
            r_wc        <= '0;
            r_ctr       <= '0;
            r_sid       <= '0;
            r_sarr      <= '0;
            r_departed  <= '0;
            r_wait_sum  <= '0;
            r_stay_sum  <= '0;
            r_area_wait <= '0;
            r_area_busy <= '0;
            r_area_all  <= '0;
            r_prev      <= '0;
        end else begin
            r_busy      <= n_busy;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_wc        <= n_wc;
            r_ctr       <= n_ctr;
            r_sid       <= n_sid;
            r_sarr      <= n_sarr;
            r_departed  <= n_departed;
            r_wait_sum  <= n_wait_sum;
            r_stay_sum  <= n_stay_sum;
            r_area_wait <= n_area_wait;
            r_area_busy <= n_area_busy;
            r_area_all  <= n_area_all;
            r_prev      <= n_prev;
        end
    end

    `SSQM_ASSERT_IMPL(a_idle_queue_empty, !r_busy, r_wc == '0)
    `SSQM_ASSERT_IMPL(a_pop_needs_entry, i_cmd.rec1 && (r_func == FUNC_DEPARTURE), r_wc != '0)
    `SSQM_ASSERT_NEXT(a_busy_after_start, i_cmd.rec1, r_busy)

endmodule

// ===== hdl/single_server_queue_monitor.sv =====
// Top level of the single server queue monitor: sequencer plus datapath.
// Depends on ssqm_pkg, ssqm_ctrl and ssqm_dp.
//
// Channel   Direction  Handshake                   Payload
// -------   ---------  --------------------------  -----------------------------
// event     in         i_in_valid / o_in_ready     i_in_data   (func, event_time)
// record    out        o_out_valid / i_out_ready   o_out_data  (trace record)
//
// An event's first record is built after its transfer in the delta, multiply,
// accumulate and first record steps, and a second record, if any, in the
// second record step; an idle-server departure emits nothing and returns to
// idle from the delta step. The step chain (time delta, 32x8 queue-area
// multiply, 64-bit accumulate, record build) uses the FIFO head read at load.
// The output register lets the next event transfer in while a record still waits.
// Reset (i_rst_n low, synchronous) clears all counters, sums and pointers at once.
// A stalled record holds the sequencer in its record step until transferred.
module single_server_queue_monitor (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ssqm_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output ssqm_pkg::t_out o_out_data
);
    import ssqm_pkg::*;

    // command strobes down, event classification back up
    t_cmd  cmd;
    t_stat stat;

    // Sequencer: accept an event, advance it one step per cycle,
    // hold in a record step while the output register is occupied.
    ssqm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Datapath: server state, wait FIFO memory, delay and area sums,
    // and the record register that drives o_out_data.
    ssqm_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_in    (i_in_data),
        .o_stat  (stat),
        .o_out   (o_out_data)
    );

endmodule

// ===== verif/tb_single_server_queue_monitor.sv =====
// Testbench for the single server queue monitor: drives timestamped arrival and
// departure events and checks every trace record against its own bookkeeping.
// Depends on ssqm_pkg and single_server_queue_monitor.
`timescale 1ns / 100ps

module tb_single_server_queue_monitor;
    import ssqm_pkg::*;

    localparam int EVENT_TARGET = 1050;  // events offered in all
    localparam int QUIET_AFTER  = 900;   // no idling past this count
    localparam int LONG_HOLD    = 300;   // receiver hold-off, in cycles
    localparam int SETTLE       = 20;    // cycles after the last record

    // Predicts the trace records of the server and checks them in order.
    class server_trace_board;
        t_out        pending_records[$];
        int unsigned errors;

        bit               busy;
        logic [PTR_W-1:0] rd_ptr;
        logic [PTR_W-1:0] wr_ptr;
        logic [CNT_W-1:0] waiting;
        logic [31:0]      last_id;
        logic [31:0]      current_id;
        logic [31:0]      current_arrival;
        logic [31:0]      departures;
        logic [31:0]      prev_time;
        logic [63:0]      wait_total;
        logic [63:0]      stay_total;
        logic [63:0]      area_queue;
        logic [63:0]      area_busy;
        logic [63:0]      area_all;
        logic [31:0]      slot_id   [QUEUE_DEPTH];
        logic [31:0]      slot_time [QUEUE_DEPTH];

        function new();
            errors          = 0;
            busy            = 1'b0;
            rd_ptr          = '0;
            wr_ptr          = '0;
            waiting         = '0;
            last_id         = '0;
            current_id      = '0;
            current_arrival = '0;
            departures      = '0;
            prev_time       = '0;
            wait_total      = '0;
            stay_total      = '0;
            area_queue      = '0;
            area_busy       = '0;
            area_all        = '0;
        endfunction

        function logic [PTR_W-1:0] step_ptr(logic [PTR_W-1:0] p);
            return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
        endfunction

        // Snapshot the totals as they stand after this record's updates.
        function void push_record(logic [1:0] kind, logic [31:0] stamp,
                                  logic [31:0] id, bit shown_busy, bit last);
            t_out r;
            r.record_kind      = kind;
            r.record_time      = stamp;
            r.item_id          = id;
            r.server_busy      = shown_busy;
            r.queue_length     = 8'(waiting);
            r.last_of_run      = last;
            r.served_count     = departures;
            r.queue_delay_sum  = wait_total;
            r.system_delay_sum = stay_total;
            r.queue_area       = area_queue;
            r.busy_area        = area_busy;
            r.system_area      = area_all;
            pending_records.push_back(r);
        endfunction

        function void note_event(t_in ev);
            logic [31:0] dt;
            logic [31:0] now;
            logic [31:0] span;
            now = ev.event_time;
            // A departure with nobody in service leaves everything alone.
            if (ev.func == FUNC_DEPARTURE && !busy)
                return;
            dt         = now - prev_time;
            prev_time  = now;
            area_queue += 64'(dt) * 64'(waiting);
            area_busy  += 64'(dt) * 64'(busy);
            area_all   += 64'(dt) * (64'(waiting) + 64'(busy));

            if (ev.func == FUNC_ARRIVAL) begin
                last_id += 1'b1;
                if (!busy) begin
                    push_record(REC_ARRIVAL, now, last_id, 1'b0, 1'b0);
                    busy            = 1'b1;
                    current_id      = last_id;
                    current_arrival = now;
                    push_record(REC_START, now, last_id, 1'b1, 1'b1);
                end else begin
                    push_record(REC_ARRIVAL, now, last_id, 1'b1, 1'b1);
                    // Drop the arrival when every slot is taken.
                    if (waiting < QUEUE_DEPTH) begin
                        slot_id[wr_ptr]   = last_id;
                        slot_time[wr_ptr] = now;
                        wr_ptr            = step_ptr(wr_ptr);
                        waiting           = waiting + 1'b1;
                    end
                end
                return;
            end

            // Time differences wrap at 32 bits before they reach the sums.
            departures += 1'b1;
            span       = now - current_arrival;
            stay_total += 64'(span);
            if (waiting != 0) begin
                push_record(REC_DEPART, now, current_id, 1'b1, 1'b0);
                current_id      = slot_id[rd_ptr];
                current_arrival = slot_time[rd_ptr];
                rd_ptr          = step_ptr(rd_ptr);
                waiting         = waiting - 1'b1;
                span            = now - current_arrival;
                wait_total      += 64'(span);
                push_record(REC_START, now, current_id, 1'b1, 1'b1);
            end else begin
                push_record(REC_DEPART, now, current_id, 1'b0, 1'b1);
                busy            = 1'b0;
                current_id      = '0;
                current_arrival = '0;
            end
        endfunction

        function void compare(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_record(t_out got);
            t_out want;
            if (pending_records.size() == 0) begin
                $error("record with nothing pending: kind %0d id %0h",
                       got.record_kind, got.item_id);
                errors++;
                return;
            end
            want = pending_records.pop_front();
            compare("record_kind",      want.record_kind,      got.record_kind);
            compare("record_time",      want.record_time,      got.record_time);
            compare("item_id",          want.item_id,          got.item_id);
            compare("server_busy",      want.server_busy,      got.server_busy);
            compare("queue_length",     want.queue_length,     got.queue_length);
            compare("last_of_run",      want.last_of_run,      got.last_of_run);
            compare("served_count",     want.served_count,     got.served_count);
            compare("queue_delay_sum",  want.queue_delay_sum,  got.queue_delay_sum);
            compare("system_delay_sum", want.system_delay_sum, got.system_delay_sum);
            compare("queue_area",       want.queue_area,       got.queue_area);
            compare("busy_area",        want.busy_area,        got.busy_area);
            compare("system_area",      want.system_area,      got.system_area);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out_data;

    server_trace_board board = new();

    // Knobs shared by the stimulus and the receiver.
    bit gaps_on;
    bit stalls_on;
    bit hold_off_req;

    // Events offered so far and the event clock.
    int unsigned counted;
    logic [31:0] clock_now;

    single_server_queue_monitor dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Watch both channels at the rising edge: note each event transfer, then
    // check each record transfer against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                board.note_event(i_in_data);
            if (o_out_valid && i_out_ready)
                board.check_record(o_out_data);
        end
    end

    // Receiver: stall in short random bursts, or hold off for a long stretch
    // on request so the block backs up and stalls its input.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                i_out_ready <= 1'b1;
            end else if (stalls_on && counted < QUIET_AFTER &&
                         $urandom_range(0, 4) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Advance the event clock: mostly small steps forward, now and then a jump
    // anywhere, a step back, or a spot just below the wrap point.
    function automatic logic [31:0] advance_time();
        case ($urandom_range(0, 39))
            0:       clock_now = $urandom();
            1:       clock_now = clock_now - $urandom_range(1, 50);
            2:       clock_now = 32'hFFFF_FFF0 + $urandom_range(0, 15);
            default: clock_now = clock_now + $urandom_range(0, 25);
        endcase
        return clock_now;
    endfunction

    // Offer one event, hold it until the transfer, then maybe idle a while.
    task automatic offer_event(input logic kind, input logic [31:0] stamp);
        i_in_valid <= 1'b1;
        i_in_data  <= '{func: kind, event_time: stamp};
        do
            @(posedge i_clk);
        while (!(i_in_valid && o_in_ready));
        @(negedge i_clk);
        counted++;
        if (gaps_on && counted < QUIET_AFTER && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
    endtask

    task automatic offer_mix(input int count, input int arrival_pct);
        repeat (count) begin
            if ($urandom_range(1, 100) <= arrival_pct)
                offer_event(FUNC_ARRIVAL, advance_time());
            else
                offer_event(FUNC_DEPARTURE, advance_time());
        end
    endtask

    // Push the FIFO past full, then drain it back down.
    task automatic fill_and_drain();
        repeat ($urandom_range(QUEUE_DEPTH + 2, QUEUE_DEPTH + 12))
            offer_event(FUNC_ARRIVAL, advance_time());
        offer_mix($urandom_range(QUEUE_DEPTH, QUEUE_DEPTH + 20), 10);
    endtask

    initial begin
        int seg_len;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        gaps_on      = 1'b1;
        stalls_on    = 1'b1;
        hold_off_req = 1'b0;
        counted      = 0;
        clock_now    = '0;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: departure while idle, immediate start, queuing, time
        // running backward and wrapping, extremes of the time field, a
        // repeated timestamp, and a return to idle.
        offer_event(FUNC_DEPARTURE, 32'd5);
        offer_event(FUNC_ARRIVAL,   32'd10);
        offer_event(FUNC_ARRIVAL,   32'd15);
        offer_event(FUNC_ARRIVAL,   32'hFFFF_FFFF);
        offer_event(FUNC_DEPARTURE, 32'd3);
        offer_event(FUNC_DEPARTURE, 32'h8000_0000);
        offer_event(FUNC_DEPARTURE, 32'h8000_0010);
        offer_event(FUNC_DEPARTURE, 32'h8000_0020);
        offer_event(FUNC_ARRIVAL,   32'd0);
        offer_event(FUNC_DEPARTURE, 32'd0);
        offer_event(FUNC_ARRIVAL,   32'h7FFF_FFFF);
        offer_event(FUNC_ARRIVAL,   32'h7FFF_FFFF);
        offer_event(FUNC_ARRIVAL,   32'd2);
        offer_event(FUNC_DEPARTURE, 32'hFFFF_FFFF);
        offer_event(FUNC_DEPARTURE, 32'h5555_5555);
        offer_event(FUNC_DEPARTURE, 32'hAAAA_AAAA);
        offer_event(FUNC_DEPARTURE, 32'hAAAA_AAB0);
        clock_now = 32'hAAAA_AAB0;

        // Back up the block: hold the receiver while the FIFO overflows.
        hold_off_req = 1'b1;
        fill_and_drain();

        // Random segments with random idling; quiet at the tail. Trim each
        // segment so the run stops near the target.
        while (counted < EVENT_TARGET) begin
            gaps_on   = (counted < QUIET_AFTER) && ($urandom_range(0, 2) != 0);
            stalls_on = (counted < QUIET_AFTER) && ($urandom_range(0, 2) != 0);
            seg_len   = $urandom_range(10, 60);
            if (seg_len > EVENT_TARGET - int'(counted))
                seg_len = EVENT_TARGET - int'(counted);
            case ($urandom_range(0, 15))
                0: begin
                    if (int'(counted) + 300 < EVENT_TARGET)
                        fill_and_drain();
                    else
                        offer_mix(seg_len, 55);
                end
                1, 2, 3: offer_mix(seg_len, 15);
                default: offer_mix(seg_len, 55);
            endcase
        end
        i_in_valid <= 1'b0;
        stalls_on  = 1'b0;

        // Drain every pending record, then give stray records time to show.
        while (board.pending_records.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        if (board.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial begin
        #4_800_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== single_server_queue_monitor.f =====
+incdir+hdl
hdl/ssqm_pkg.sv
hdl/ssqm_ctrl.sv
hdl/ssqm_dp.sv
hdl/single_server_queue_monitor.sv
verif/tb_single_server_queue_monitor.sv
